### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define FPMS_ASSERT_NOW(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("fpms check failed in the same cycle");

// condition must hold in the cycle after the trigger
`define FPMS_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("fpms check failed one cycle later");

`endif

### rtl/fpms_pkg.sv
// shared types and constants for the first pattern match search block
package fpms_pkg;

    // default sizes
    localparam int P_MAX_PATTERN   = 128;
    localparam int P_POSITION_BITS = 24;

    // fixed field widths
    localparam int LEN_W   = 8;
    localparam int SLOT_W  = 7;
    localparam int CHAR_W  = 8;
    localparam int START_W = 24;

    // input commands
    typedef enum logic [1:0] {
        CMD_RESTART = 2'd0,
        CMD_PATTERN = 2'd1,
        CMD_TEXT    = 2'd2,
        CMD_END     = 2'd3
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_NONE      = 2'd0,
        ST_FIRST     = 2'd1,
        ST_ALREADY   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // control from the top level to the compare row
    typedef struct packed {
        logic              clear;
        logic              write;
        logic              advance;
        logic [SLOT_W-1:0] slot;
        logic [CHAR_W-1:0] data;
    } t_row_ctrl;

endpackage

### rtl/fpms_if.sv
// valid/ready channel interfaces for input items, results and configuration

// input item channel
interface fpms_in_if import fpms_pkg::*; ();
    logic              valid;
    logic              ready;
    t_cmd              command;
    logic [CHAR_W-1:0] character;
    logic [SLOT_W-1:0] pattern_slot;

    modport source (output valid, output command, output character, output pattern_slot,
                    input ready);
    modport sink   (input valid, input command, input character, input pattern_slot,
                    output ready);
endinterface

// result channel
interface fpms_out_if import fpms_pkg::*; ();
    logic               valid;
    logic               ready;
    t_status            status;
    logic [START_W-1:0] match_start;

    modport source (output valid, output status, output match_start, input ready);
    modport sink   (input valid, input status, input match_start, output ready);
endinterface

// pattern length write channel
interface fpms_cfg_if import fpms_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/fpms_match_row.sv
// pattern store and row of per-alignment partial match bits
module fpms_match_row import fpms_pkg::*; #(
    parameter int MAX_PATTERN = P_MAX_PATTERN,
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_row_ctrl        i_ctrl,
    input  logic [IDX_W-1:0] i_len_m1,
    output logic             o_hit
);

    logic [CHAR_W-1:0]      r_pat [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] r_bits;
    logic [MAX_PATTERN-1:0] n_bits;
    logic [MAX_PATTERN-1:0] w_shift;
    logic [MAX_PATTERN-1:0] w_keep;
    logic [MAX_PATTERN-1:0] w_adv;

    // every alignment compares its pattern byte against the text byte at once
    always_comb begin
        w_shift = (r_bits << 1) | MAX_PATTERN'(1);
        for (int j = 0; j < MAX_PATTERN; j++) begin
            w_keep[j] = (r_pat[j] == i_ctrl.data) && (j <= int'(i_len_m1));
        end
        w_adv = w_shift & w_keep;
        o_hit = i_ctrl.advance && w_adv[i_len_m1];
    end

    // next partial bits
    always_comb begin
        if (i_ctrl.clear) begin
            n_bits = '0;
        end else if (i_ctrl.advance) begin
            n_bits = w_adv;
        end else begin
            n_bits = r_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
        end else begin
            r_bits <= n_bits;
        end
    end

    // pattern byte write, slots past the store are dropped
    always_ff @(posedge i_clk) begin
        if (i_ctrl.write && (int'(i_ctrl.slot) < MAX_PATTERN)) begin
            r_pat[IDX_W'(i_ctrl.slot)] <= i_ctrl.data;
        end
    end

endmodule

### rtl/first_pattern_match_search.sv
// top level of the first pattern match search block
// a result beat appears in the cycle after its input beat is accepted
// one input beat per cycle unless stalled, the output register is the only stage
// an input beat is taken whenever the output register is empty or being drained
// reset clears the match bits, position, found state and output valid; length goes to 1
// pattern bytes are not cleared by reset and must be written before use
module first_pattern_match_search import fpms_pkg::*; #(
    parameter int MAX_PATTERN   = P_MAX_PATTERN,
    parameter int POSITION_BITS = P_POSITION_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpms_in_if.sink     i_in,
    fpms_out_if.source  o_out,
    fpms_cfg_if.sink    i_cfg
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [LEN_W-1:0]         r_len;
    logic [POSITION_BITS-1:0] r_text_pos;
    logic [POSITION_BITS-1:0] n_text_pos;
    logic                     r_found;
    logic                     n_found;
    logic [POSITION_BITS-1:0] r_found_pos;
    logic [POSITION_BITS-1:0] n_found_pos;
    logic                     r_out_valid;
    t_status                  r_status;
    t_status                  n_status;
    logic [START_W-1:0]       r_start;
    logic [START_W-1:0]       n_start;

    logic                     w_fire;
    logic                     w_pos_max;
    logic [IDX_W-1:0]         w_len_m1;
    logic [POSITION_BITS-1:0] w_hit_pos;
    logic                     w_hit;
    t_row_ctrl                w_ctrl;

    // handshakes
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;
    assign w_fire      = i_in.valid && i_in.ready;

    // pattern length in use minus one, zero read as one, saturated to the store
    always_comb begin
        if (r_len == '0) begin
            w_len_m1 = '0;
        end else if (int'(r_len) > MAX_PATTERN) begin
            w_len_m1 = IDX_W'(MAX_PATTERN - 1);
        end else begin
            w_len_m1 = IDX_W'(r_len - LEN_W'(1));
        end
    end

    assign w_pos_max = &r_text_pos;
    assign w_hit_pos = r_text_pos - POSITION_BITS'(w_len_m1);

    // compare row control
    always_comb begin
        w_ctrl.clear   = 1'b0;
        w_ctrl.write   = 1'b0;
        w_ctrl.advance = 1'b0;
        w_ctrl.slot    = i_in.pattern_slot;
        w_ctrl.data    = i_in.character;
        if (w_fire) begin
            case (i_in.command)
                CMD_RESTART: begin
                    w_ctrl.clear = 1'b1;
                end
                CMD_PATTERN: begin
                    w_ctrl.write = 1'b1;
                end
                CMD_TEXT: begin
                    if (!r_found) begin
                        w_ctrl.clear   = w_pos_max;
                        w_ctrl.advance = !w_pos_max;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    fpms_match_row #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_row (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_len_m1 (w_len_m1),
        .o_hit    (w_hit)
    );

    // search state and result for the accepted beat
    always_comb begin
        n_text_pos  = r_text_pos;
        n_found     = r_found;
        n_found_pos = r_found_pos;
        n_status    = ST_NONE;
        n_start     = '0;
        case (i_in.command)
            CMD_RESTART: begin
                n_text_pos  = '0;
                n_found     = 1'b0;
                n_found_pos = '0;
            end
            CMD_PATTERN: begin
            end
            CMD_TEXT: begin
                if (r_found) begin
                    n_status = ST_ALREADY;
                    n_start  = START_W'(32'(r_found_pos));
                end else if (w_hit) begin
                    n_found     = 1'b1;
                    n_found_pos = w_hit_pos;
                    n_status    = ST_FIRST;
                    n_start     = START_W'(32'(w_hit_pos));
                end
                if (!w_pos_max) begin
                    n_text_pos = r_text_pos + POSITION_BITS'(1);
                end
            end
            CMD_END: begin
                if (r_found) begin
                    n_status = ST_ALREADY;
                    n_start  = START_W'(32'(r_found_pos));
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    // search state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_pos  <= '0;
            r_found     <= 1'b0;
            r_found_pos <= '0;
        end else if (w_fire) begin
            r_text_pos  <= n_text_pos;
            r_found     <= n_found;
            r_found_pos <= n_found_pos;
        end
    end

    // pattern length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(1);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_len <= i_cfg.data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status <= n_status;
            r_start  <= n_start;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.match_start = r_start;

endmodule

### rtl/fpms_checker.sv
// port-level checks for the first pattern match search block, with its bind
`include "assert_macros.svh"

module fpms_checker import fpms_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input t_status            i_out_status,
    input logic [START_W-1:0] i_out_start
);

    logic w_no_match;

    // result beat that carries no match position
    assign w_no_match = i_out_valid && (i_out_status == ST_NONE || i_out_status == ST_NOT_FOUND);

    // a stalled result beat stays offered
    `FPMS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // every accepted input beat yields a result beat in the next cycle
    `FPMS_ASSERT_NEXT(a_in_to_out, i_clk, i_rst_n, i_in_valid && i_in_ready, i_out_valid)

    // an empty output register never blocks the input
    `FPMS_ASSERT_NOW(a_ready_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)

    // start index is zero unless a match is reported
    `FPMS_ASSERT_NOW(a_start_zero, i_clk, i_rst_n, w_no_match, i_out_start == '0)

endmodule

bind first_pattern_match_search fpms_checker u_fpms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_start  (o_out.match_start)
);
